@@ sv/ang_pkg.sv @@
// Shared constants, register indexes and reset values for the audio noise gate.
package ang_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_FRAC_BITS = 15;
   localparam int GAIN_WIDTH     = GAIN_FRAC_BITS + 1;

   localparam int THRESH_WIDTH   = 31;
   localparam int LEN_WIDTH      = 16;
   localparam int DEBOUNCE_WIDTH = 24;
   localparam int SUM_WIDTH      = 46;
   localparam int LEVEL_WIDTH    = 31;
   localparam int SQ_WIDTH       = 31;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 31;
   localparam int DIV_CNT_WIDTH  = $clog2(SUM_WIDTH + 1);
   localparam int WPOS_STEPS     = LEN_WIDTH + 1;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_THRESHOLD       = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ATTACK_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RELEASE_LENGTH  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WINDOW_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE_LENGTH = 3'd4;

   localparam logic [THRESH_WIDTH-1:0]   RST_THRESHOLD       = 31'd10737;
   localparam logic [LEN_WIDTH-1:0]      RST_ATTACK_LENGTH   = 16'd48;
   localparam logic [LEN_WIDTH-1:0]      RST_RELEASE_LENGTH  = 16'd480;
   localparam logic [LEN_WIDTH-1:0]      RST_WINDOW_LENGTH   = 16'd480;
   localparam logic [DEBOUNCE_WIDTH-1:0] RST_DEBOUNCE_LENGTH = 24'd24000;

   // Squares are scaled so that full scale squared is 2^30.
   localparam int SQ_RSHIFT = (SAMPLE_WIDTH >= 16) ? 2 * (SAMPLE_WIDTH - 16) : 0;
   localparam int SQ_LSHIFT = (SAMPLE_WIDTH < 16) ? 2 * (16 - SAMPLE_WIDTH) : 0;

endpackage

@@ sv/audio_noise_gate_core.sv @@
// Noise gate with linear attack and release gain ramps, built around one serial divider.
//
// The block takes one signed sample per transaction and returns it scaled by the
// current gain together with the gate state. A single restoring divider, one quotient
// bit per cycle, produces the ramp gain, the window position modulo the window length
// when a shortened window leaves it out of range and the mean-square level at each
// window wrap. A sample outside any ramp and inside a window passes through the window,
// decide and output states; a ramp sample adds the gain division, a window wrap adds
// the level division and a window position left out of range adds the modulo division.
// The result sits in an output register, and the next sample is taken while it waits.
// Configuration writes are taken at any time and must only be issued while the block
// is idle.
module audio_noise_gate_core
   import ang_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_in_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_out_sample,
   output logic                             rsp_gate_is_open,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]         csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_GAIN   = 3'd1;
   localparam logic [2:0] ST_WIN    = 3'd2;
   localparam logic [2:0] ST_MOD    = 3'd3;
   localparam logic [2:0] ST_LVL    = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   localparam int PROD_WIDTH = SAMPLE_WIDTH + GAIN_WIDTH + 1;

   logic [2:0]                    state_ff, state_in;
   logic [THRESH_WIDTH-1:0]       threshold_ff, threshold_in;
   logic [LEN_WIDTH-1:0]          attack_length_ff, attack_length_in;
   logic [LEN_WIDTH-1:0]          release_length_ff, release_length_in;
   logic [LEN_WIDTH-1:0]          window_length_ff, window_length_in;
   logic [DEBOUNCE_WIDTH-1:0]     debounce_length_ff, debounce_length_in;
   logic [LEN_WIDTH-1:0]          attack_left_ff, attack_left_in;
   logic [LEN_WIDTH-1:0]          release_left_ff, release_left_in;
   logic [DEBOUNCE_WIDTH-1:0]     debounce_left_ff, debounce_left_in;
   logic [LEN_WIDTH-1:0]          wpos_ff, wpos_in;
   logic [SUM_WIDTH-1:0]          square_sum_ff, square_sum_in;
   logic [LEVEL_WIDTH-1:0]        level_ff, level_in;
   logic                          gate_ff, gate_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic [SQ_WIDTH-1:0]            sq_ff, sq_in;
   logic [GAIN_WIDTH-1:0]          gain_ff, gain_in;
   logic [LEN_WIDTH-1:0]           div_rem_ff, div_rem_in;
   logic [SUM_WIDTH-1:0]           div_dvd_ff, div_dvd_in;
   logic [LEN_WIDTH-1:0]           div_den_ff, div_den_in;
   logic [DIV_CNT_WIDTH-1:0]       div_cnt_ff, div_cnt_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_gate_ff, rsp_gate_in;

   logic [LEN_WIDTH:0]             div_trial;
   logic [LEN_WIDTH:0]             div_diff;
   logic                           div_ge;
   logic [LEN_WIDTH-1:0]           div_rem_step;
   logic [LEN_WIDTH-1:0]           wlen_eff;
   logic [LEN_WIDTH:0]             wpos_plus;
   logic signed [2*SAMPLE_WIDTH-1:0] x_square;
   logic [63:0]                    sq_wide;
   logic signed [PROD_WIDTH-1:0]   prod;
   logic                           req_take;
   logic                           rsp_take;

   assign div_trial    = {div_rem_ff, div_dvd_ff[SUM_WIDTH-1]};
   assign div_diff     = div_trial - {1'b0, div_den_ff};
   assign div_ge       = div_trial >= {1'b0, div_den_ff};
   assign div_rem_step = div_ge ? div_diff[LEN_WIDTH-1:0] : div_trial[LEN_WIDTH-1:0];

   assign wlen_eff  = (window_length_ff == '0) ? LEN_WIDTH'(1) : window_length_ff;
   assign wpos_plus = {1'b0, wpos_ff} + (LEN_WIDTH+1)'(1);

   assign x_square = req_in_sample * req_in_sample;
   assign sq_wide  = (64'(unsigned'(x_square)) >> SQ_RSHIFT) << SQ_LSHIFT;

   assign prod = PROD_WIDTH'(x_ff) * PROD_WIDTH'($signed({1'b0, gain_ff}));

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = rsp_sample_ff;
   assign rsp_gate_is_open = rsp_gate_ff;

   always_comb begin
      state_in           = state_ff;
      threshold_in       = threshold_ff;
      attack_length_in   = attack_length_ff;
      release_length_in  = release_length_ff;
      window_length_in   = window_length_ff;
      debounce_length_in = debounce_length_ff;
      attack_left_in     = attack_left_ff;
      release_left_in    = release_left_ff;
      debounce_left_in   = debounce_left_ff;
      wpos_in            = wpos_ff;
      square_sum_in      = square_sum_ff;
      level_in           = level_ff;
      gate_in            = gate_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_take;
      x_in               = x_ff;
      sq_in              = sq_ff;
      gain_in            = gain_ff;
      div_rem_in         = div_rem_ff;
      div_dvd_in         = div_dvd_ff;
      div_den_in         = div_den_ff;
      div_cnt_in         = div_cnt_ff;
      rsp_sample_in      = rsp_sample_ff;
      rsp_gate_in        = rsp_gate_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD:       threshold_in       = csr_data[THRESH_WIDTH-1:0];
            CSR_ATTACK_LENGTH:   attack_length_in   = csr_data[LEN_WIDTH-1:0];
            CSR_RELEASE_LENGTH:  release_length_in  = csr_data[LEN_WIDTH-1:0];
            CSR_WINDOW_LENGTH:   window_length_in   = csr_data[LEN_WIDTH-1:0];
            CSR_DEBOUNCE_LENGTH: debounce_length_in = csr_data[DEBOUNCE_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_in       = req_in_sample;
               sq_in      = sq_wide[SQ_WIDTH-1:0];
               state_in   = ST_WIN;
               div_rem_in = '0;
               div_dvd_in = '0;
               div_cnt_in = DIV_CNT_WIDTH'(GAIN_FRAC_BITS);
               if (debounce_left_ff != '0) begin
                  debounce_left_in = debounce_left_ff - DEBOUNCE_WIDTH'(1);
               end
               if (attack_left_ff != '0) begin
                  attack_left_in = attack_left_ff - LEN_WIDTH'(1);
                  if (attack_left_ff >= attack_length_ff) begin
                     gain_in = '0;
                  end else begin
                     div_rem_in = attack_length_ff - attack_left_ff;
                     div_den_in = attack_length_ff;
                     state_in   = ST_GAIN;
                  end
               end else if (release_left_ff != '0) begin
                  release_left_in = release_left_ff - LEN_WIDTH'(1);
                  if (release_left_ff >= release_length_ff) begin
                     gain_in = GAIN_WIDTH'(1) << GAIN_FRAC_BITS;
                  end else begin
                     div_rem_in = release_left_ff;
                     div_den_in = release_length_ff;
                     state_in   = ST_GAIN;
                  end
               end else begin
                  gain_in = gate_ff ? (GAIN_WIDTH'(1) << GAIN_FRAC_BITS) : '0;
               end
            end
         end
         ST_GAIN, ST_MOD, ST_LVL: begin
            if (div_cnt_ff != '0) begin
               div_rem_in = div_rem_step;
               div_dvd_in = {div_dvd_ff[SUM_WIDTH-2:0], div_ge};
               div_cnt_in = div_cnt_ff - DIV_CNT_WIDTH'(1);
            end else if (state_ff == ST_GAIN) begin
               gain_in  = {1'b0, div_dvd_ff[GAIN_FRAC_BITS-1:0]};
               state_in = ST_WIN;
            end else if (state_ff == ST_MOD) begin
               wpos_in = div_rem_ff;
               if (div_rem_ff == '0) begin
                  div_rem_in = '0;
                  div_dvd_in = square_sum_ff;
                  div_den_in = wlen_eff;
                  div_cnt_in = DIV_CNT_WIDTH'(SUM_WIDTH);
                  state_in   = ST_LVL;
               end else begin
                  square_sum_in = square_sum_ff + SUM_WIDTH'(sq_ff);
                  state_in      = ST_DECIDE;
               end
            end else begin
               level_in      = div_dvd_ff[LEVEL_WIDTH-1:0];
               square_sum_in = '0;
               state_in      = ST_DECIDE;
            end
         end
         ST_WIN: begin
            if (wpos_plus < {1'b0, wlen_eff}) begin
               wpos_in       = wpos_plus[LEN_WIDTH-1:0];
               square_sum_in = square_sum_ff + SUM_WIDTH'(sq_ff);
               state_in      = ST_DECIDE;
            end else if (wpos_plus == {1'b0, wlen_eff}) begin
               wpos_in    = '0;
               div_rem_in = '0;
               div_dvd_in = square_sum_ff;
               div_den_in = wlen_eff;
               div_cnt_in = DIV_CNT_WIDTH'(SUM_WIDTH);
               state_in   = ST_LVL;
            end else begin
               div_rem_in = '0;
               div_dvd_in = {wpos_plus, (SUM_WIDTH-WPOS_STEPS)'(0)};
               div_den_in = wlen_eff;
               div_cnt_in = DIV_CNT_WIDTH'(WPOS_STEPS);
               state_in   = ST_MOD;
            end
         end
         ST_DECIDE: begin
            if (debounce_left_ff == '0) begin
               if (gate_ff && (level_ff <= threshold_ff)) begin
                  gate_in         = 1'b0;
                  release_left_in = release_length_ff;
               end else if (!gate_ff && (level_ff > threshold_ff)) begin
                  gate_in          = 1'b1;
                  attack_left_in   = attack_length_ff;
                  debounce_left_in = debounce_length_ff;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_sample_in = prod[GAIN_FRAC_BITS+SAMPLE_WIDTH-1:GAIN_FRAC_BITS];
               rsp_gate_in   = gate_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         threshold_ff       <= RST_THRESHOLD;
         attack_length_ff   <= RST_ATTACK_LENGTH;
         release_length_ff  <= RST_RELEASE_LENGTH;
         window_length_ff   <= RST_WINDOW_LENGTH;
         debounce_length_ff <= RST_DEBOUNCE_LENGTH;
         attack_left_ff     <= '0;
         release_left_ff    <= '0;
         debounce_left_ff   <= '0;
         wpos_ff            <= '0;
         square_sum_ff      <= '0;
         level_ff           <= '0;
         gate_ff            <= 1'b1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         threshold_ff       <= threshold_in;
         attack_length_ff   <= attack_length_in;
         release_length_ff  <= release_length_in;
         window_length_ff   <= window_length_in;
         debounce_length_ff <= debounce_length_in;
         attack_left_ff     <= attack_left_in;
         release_left_ff    <= release_left_in;
         debounce_left_ff   <= debounce_left_in;
         wpos_ff            <= wpos_in;
         square_sum_ff      <= square_sum_in;
         level_ff           <= level_in;
         gate_ff            <= gate_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      sq_ff         <= sq_in;
      gain_ff       <= gain_in;
      div_rem_ff    <= div_rem_in;
      div_dvd_ff    <= div_dvd_in;
      div_den_ff    <= div_den_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_gate_ff   <= rsp_gate_in;
   end

endmodule

@@ sv/ang_checker.sv @@
// Port-level checks for the audio noise gate, bound to the top level.
module ang_checker
   import ang_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   input logic                           rsp_gate_is_open
);

   // A response transaction that is stalled stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_sample) && $stable(rsp_gate_is_open))
      else $error("response payload changed while stalled");

   // Each accepted request keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on consecutive cycles");

   // Reset leaves the block ready for a request with no response pending.
   assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind audio_noise_gate_core ang_checker u_ang_checker (.*);
